FILE: hdl/mpdt_pkg.sv
// shared types and constants for the multi-pump dose timer
package mpdt_pkg;

    // pump count and derived widths
    localparam int PUMPS     = 4;
    localparam int PUMP_W    = (PUMPS > 1) ? $clog2(PUMPS) : 1;
    localparam int MS_W      = 32;
    localparam int VOL_W     = 16;
    localparam int RATE_W    = 16;
    localparam int NEED_W    = 32;
    localparam int DOSED_W   = MS_W + RATE_W;
    localparam int MASK_W    = 4;
    localparam int COUNT_W   = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    // milliseconds in one minute, and volume limits after reset
    localparam logic [VOL_W-1:0] MS_PER_MIN  = 16'd60000;
    localparam logic [VOL_W-1:0] MIN_DOSE_RST = 16'd10;
    localparam logic [VOL_W-1:0] MAX_DOSE_RST = 16'd50000;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_START  = 2'd1,
        OP_CANCEL = 2'd2,
        OP_QUERY  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_DOSING = 2'd1,
        PH_DONE   = 2'd2,
        PH_ERR    = 2'd3
    } t_phase;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE0  = 3'd0,
        CFG_RATE1  = 3'd1,
        CFG_RATE2  = 3'd2,
        CFG_RATE3  = 3'd3,
        CFG_ACTIVE = 3'd4,
        CFG_MIN    = 3'd5,
        CFG_MAX    = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OP,
        S_MUL,
        S_CMP,
        S_FIN
    } t_state;

    typedef struct packed {
        t_opcode           opcode;
        logic [2:0]        pump_select;
        logic [VOL_W-1:0]  dose_volume;
    } t_in_item;

    typedef struct packed {
        logic               op_ok;
        t_phase             queried_phase;
        logic [MASK_W-1:0]  run_mask;
        logic [MASK_W-1:0]  done_mask;
        logic [MASK_W-1:0]  fault_mask;
        logic [COUNT_W-1:0] active_count;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic              latch;
        logic              op_step;
        logic              mul;
        logic              cmp;
        logic              load_out;
        logic [PUMP_W-1:0] pump;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_tick;
    } t_dp_stat;

endpackage

FILE: hdl/multi_pump_dose_timer_top.sv
// top level of the multi-pump dose timer
// Dosing job table for PUMPS pumps. One item is taken at a time: a start,
// cancel or query is applied and then goes straight to the result, while
// a tick walks the pumps one by one through a shared multiply step
// (elapsed ms times rate, and volume times 60000) and a compare step.
// A finished result sits in an output register, so the next item is
// taken while it waits to transfer.
// Rate and limit registers may be written at any time the block is idle.
module multi_pump_dose_timer_top
    import mpdt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // controller
    mpdt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // datapath
    mpdt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: hdl/mpdt_ctrl.sv
// sequencing state machine: accept, apply, per-pump tick visits, result hand-off
module mpdt_ctrl
    import mpdt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state            r_state, n_state;
    logic [PUMP_W-1:0] r_pump, n_pump;
    logic              r_out_valid, n_out_valid;
    logic              w_slot_free;

    // output slot is free when empty or being drained this cycle
    assign w_slot_free = !r_out_valid || !i_out_stall;

    // state, pump counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pump      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pump      <= n_pump;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state       = r_state;
        n_pump        = r_pump;
        o_cmd         = '0;
        o_cmd.pump    = r_pump;
        n_out_valid   = r_out_valid && i_out_stall;
        o_in_stall    = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_OP;
                end
            end
            S_OP: begin
                o_cmd.op_step = 1'b1;
                n_pump        = '0;
                n_state       = i_stat.is_tick ? S_MUL : S_FIN;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                if (r_pump == PUMP_W'(PUMPS - 1)) begin
                    n_state = S_FIN;
                end else begin
                    n_pump  = r_pump + 1'b1;
                    n_state = S_MUL;
                end
            end
            S_FIN: begin
                if (w_slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: hdl/mpdt_dp.sv
// datapath: config registers, job table, tick arithmetic and result register
module mpdt_dp
    import mpdt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    input  t_in_item             i_in_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output t_out_item            o_out_data
);

    // configuration
    logic [RATE_W-1:0]  r_rate [PUMPS];
    logic [MASK_W-1:0]  r_active;
    logic [VOL_W-1:0]   r_min;
    logic [VOL_W-1:0]   r_max;

    // job table
    logic [MS_W-1:0]    r_ms;
    t_phase             r_phase     [PUMPS];
    logic [VOL_W-1:0]   r_job_vol   [PUMPS];
    logic [MS_W-1:0]    r_job_start [PUMPS];

    // latched item and working registers
    t_opcode            r_op;
    logic [2:0]         r_sel;
    logic [VOL_W-1:0]   r_vol;
    logic               r_ok;
    logic [DOSED_W-1:0] r_dosed;
    logic [NEED_W-1:0]  r_need;
    logic [MASK_W-1:0]  r_done;
    logic [MASK_W-1:0]  r_fault;
    t_out_item          r_out;

    logic               w_valid;
    logic [PUMP_W-1:0]  w_idx;
    logic [MS_W-1:0]    w_elapsed;
    logic               w_start_ok;
    logic [MASK_W-1:0]  w_run;
    logic [COUNT_W-1:0] w_count;
    t_phase             w_qphase;

    assign w_valid   = r_sel < 3'(PUMPS);
    assign w_idx     = r_sel[PUMP_W-1:0];
    assign w_elapsed = r_ms - r_job_start[i_cmd.pump];
    assign o_stat.is_tick = (r_op == OP_TICK);

    // start checks: index, volume window, not already dosing, pump enabled
    assign w_start_ok = w_valid && (r_vol >= r_min) && (r_vol <= r_max)
                     && (r_phase[w_idx] != PH_DOSING) && r_active[r_sel[1:0]];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PUMPS; p++) begin
                r_rate[p] <= '0;
            end
            r_active <= '0;
            r_min    <= MIN_DOSE_RST;
            r_max    <= MAX_DOSE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index) inside
                CFG_RATE0, CFG_RATE1, CFG_RATE2, CFG_RATE3: begin
                    if (i_cfg_index < CFG_IDX_W'(PUMPS)) begin
                        r_rate[i_cfg_index[PUMP_W-1:0]] <= i_cfg_data;
                    end
                end
                CFG_ACTIVE: r_active <= i_cfg_data[MASK_W-1:0];
                CFG_MIN:    r_min    <= i_cfg_data;
                CFG_MAX:    r_max    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // millisecond counter and job phases
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms <= '0;
            for (int p = 0; p < PUMPS; p++) begin
                r_phase[p] <= PH_IDLE;
            end
        end else if (i_cmd.op_step) begin
            case (r_op)
                OP_TICK:   r_ms <= r_ms + 1'b1;
                OP_START: begin
                    if (w_start_ok) begin
                        r_phase[w_idx] <= PH_DOSING;
                    end
                end
                OP_CANCEL: begin
                    if (w_valid) begin
                        r_phase[w_idx] <= PH_IDLE;
                    end
                end
                default: begin
                end
            endcase
        end else if (i_cmd.cmp) begin
            case (r_phase[i_cmd.pump])
                PH_DONE, PH_ERR: r_phase[i_cmd.pump] <= PH_IDLE;
                PH_DOSING: begin
                    if (r_rate[i_cmd.pump] == '0) begin
                        r_phase[i_cmd.pump] <= PH_ERR;
                    end else if (r_dosed >= DOSED_W'(r_need)) begin
                        r_phase[i_cmd.pump] <= PH_DONE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // item latch, job payload, ok flag and tick event masks
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op    <= i_in_data.opcode;
            r_sel   <= i_in_data.pump_select;
            r_vol   <= i_in_data.dose_volume;
            r_done  <= '0;
            r_fault <= '0;
        end
        if (i_cmd.op_step) begin
            case (r_op)
                OP_TICK:  r_ok <= 1'b1;
                OP_START: r_ok <= w_start_ok;
                default:  r_ok <= w_valid;
            endcase
            if (r_op == OP_START && w_start_ok) begin
                r_job_vol[w_idx]   <= r_vol;
                r_job_start[w_idx] <= r_ms;
            end
        end
        // dosed = elapsed * rate, need = volume * ms per minute
        if (i_cmd.mul) begin
            r_dosed <= DOSED_W'(w_elapsed) * DOSED_W'(r_rate[i_cmd.pump]);
            r_need  <= NEED_W'(r_job_vol[i_cmd.pump]) * NEED_W'(MS_PER_MIN);
        end
        if (i_cmd.cmp && r_phase[i_cmd.pump] == PH_DOSING) begin
            if (r_rate[i_cmd.pump] == '0) begin
                r_fault[i_cmd.pump] <= 1'b1;
            end else if (r_dosed >= DOSED_W'(r_need)) begin
                r_done[i_cmd.pump] <= 1'b1;
            end
        end
        if (i_cmd.load_out) begin
            r_out <= '{op_ok:         r_ok,
                       queried_phase: w_qphase,
                       run_mask:      w_run,
                       done_mask:     r_done,
                       fault_mask:    r_fault,
                       active_count:  w_count};
        end
    end

    // run mask, dosing count and queried phase
    always_comb begin
        w_run   = '0;
        w_count = '0;
        for (int p = 0; p < PUMPS; p++) begin
            if (r_phase[p] == PH_DOSING) begin
                w_run[p] = 1'b1;
                w_count  = w_count + 1'b1;
            end
        end
        w_qphase = w_valid ? r_phase[w_idx] : PH_ERR;
    end

    assign o_out_data = r_out;

endmodule

FILE: hdl/mpdt_chk.sv
// port-level checker for the multi-pump dose timer, bound to the top level
module mpdt_chk
    import mpdt_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_stall,
    input logic      i_out_valid,
    input logic      i_out_stall,
    input t_out_item i_out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

    // one item at a time: after a transfer in, the input side stalls
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_stall |=> i_in_stall)
        else $error("input taken while an item is in work");

    // dosing count agrees with the run mask
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_data.active_count == $countones(i_out_data.run_mask))
        else $error("active count does not match run mask");

    // a pump cannot both finish and fault, and neither leaves it running
    a_masks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_out_data.done_mask & i_out_data.fault_mask) == '0)
                     && (((i_out_data.done_mask | i_out_data.fault_mask)
                          & i_out_data.run_mask) == '0))
        else $error("event masks overlap");

endmodule

bind multi_pump_dose_timer_top mpdt_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);
